FILE: hw/rtl/ppue_pkg.sv
// Shared constants, types and helpers of the particle pool update engine.
`default_nettype none

package ppue_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 1024;
    localparam int ADDR_W    = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam logic [CNT_W-1:0] POOL_CNT   = CNT_W'(POOL_SIZE);
    localparam logic [CNT_W-1:0] CLEAR_LAST = CNT_W'(POOL_SIZE - 1);
    localparam logic [ADDR_W-1:0] TOP_SLOT  = ADDR_W'(POOL_SIZE - 1);

    // Field widths
    localparam int FUNC_W = 2;
    localparam int FIX_W  = 32;
    localparam int AMT_W  = 31;
    localparam int RAND_W = 16;
    localparam int VARY_W = 31;
    localparam int SLOT_W = 10;
    localparam int NUM_W  = 11;

    // Stream and register port widths
    localparam int IN_W   = 288;
    localparam int OUT_W  = 240;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_EMIT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_VARY_X = 2'd0;
    localparam logic [1:0] REG_VARY_Y = 2'd1;
    localparam logic [1:0] REG_VARY_Z = 2'd2;

    // One half in Q0.16, as a 17-bit signed value
    localparam logic signed [RAND_W:0] RAND_HALF = 17'sd32768;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EMIT_MUL,
        ST_EMIT_WR,
        ST_TICK,
        ST_READ_RD,
        ST_READ_DT,
        ST_RESP
    } t_state;

    // One slot of the particle memory
    typedef struct packed {
        logic [FIX_W-1:0]        life;
        logic [2:0][FIX_W-1:0]   vel;
        logic [2:0][FIX_W-1:0]   pos;
    } t_particle;

    localparam int PART_W = $bits(t_particle);

    // One input beat, unpacked
    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [2:0][FIX_W-1:0]   pos;
        logic [2:0][FIX_W-1:0]   vel;
        logic [AMT_W-1:0]        amount;
        logic [2:0][RAND_W-1:0]  rnd;
        logic [SLOT_W-1:0]       slot;
    } t_item;

    // One result beat
    typedef struct packed {
        logic [NUM_W-1:0]        number;
        logic                    is_active;
        logic [FIX_W-1:0]        life;
        logic [2:0][FIX_W-1:0]   vel;
        logic [2:0][FIX_W-1:0]   pos;
    } t_result;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic [FIX_W-1:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX) begin
            return 32'h7FFF_FFFF;
        end else if (v < S32_MIN) begin
            return 32'h8000_0000;
        end
        return v[FIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ppue_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ppue_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/particle_pool_update_engine.sv
// Particle pool update engine: emit, tick and read over a memory-held pool.
// Emit steps through ST_EMIT_MUL and ST_EMIT_WR, read through ST_READ_RD and
// ST_READ_DT; tick walks the pool through the memory read port, one slot a cycle,
// then drains its write-back pipeline; every operation, unknown ones too, ends in ST_RESP.
// One operation at a time; the next beat is taken while a result still waits.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every slot of
// the active-flag memory while s_axis_tready stays low.
`default_nettype none

module particle_pool_update_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Input stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, amount, rand_x, rand_y,
    //        rand_z, slot, zero fill
    input  wire logic [ppue_pkg::IN_W-1:0]     i_s_axis_tdata,
    // tuser: func
    input  wire logic [ppue_pkg::FUNC_W-1:0]   i_s_axis_tuser,
    // Output stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // tdata: out_x, out_y, out_z, out_vx, out_vy, out_vz, life_left, is_active,
    //        number, zero fill
    output logic      [ppue_pkg::OUT_W-1:0]    o_m_axis_tdata,
    // Configuration port
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [ppue_pkg::APB_AW-1:0]   i_paddr,
    input  wire logic [ppue_pkg::APB_DW-1:0]   i_pwdata,
    output logic      [ppue_pkg::APB_DW-1:0]   o_prdata,
    output logic                               o_pready
);

    localparam int AW = ppue_pkg::ADDR_W;
    localparam int CW = ppue_pkg::CNT_W;

    // Control state
    ppue_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_idx;
    logic [AW-1:0]    r_wptr;
    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid;
    logic [2:0][ppue_pkg::VARY_W-1:0] r_vary;

    // Tick pipeline valids and addresses
    logic             r_v1, r_v2;
    logic [AW-1:0]    r_a1, r_a2;

    // Payload
    ppue_pkg::t_item     in_item, r_item;
    ppue_pkg::t_result   r_res, r_out;
    ppue_pkg::t_particle r_part2;
    logic                r_live2;
    logic signed [2:0][63:0] r_prod2;
    logic signed [2:0][48:0] r_jit;

    // Memory ports
    logic                flag_we, flag_wdata, flag_rd;
    logic [AW-1:0]       flag_waddr, flag_raddr;
    logic                part_we;
    logic [AW-1:0]       part_waddr, part_raddr;
    ppue_pkg::t_particle part_wdata, part_rd;

    // Datapath results
    logic                s_acc, out_free, cfg_wr, tick_issue, tick_done;
    logic                tick_kill, tick_wr, read_in_range;
    ppue_pkg::t_particle emit_part, tick_part;

    // Input unpacking
    always_comb begin
        in_item.func   = i_s_axis_tuser;
        in_item.pos    = i_s_axis_tdata[95:0];
        in_item.vel    = i_s_axis_tdata[191:96];
        in_item.amount = i_s_axis_tdata[222:192];
        in_item.rnd    = i_s_axis_tdata[270:223];
        in_item.slot   = i_s_axis_tdata[280:271];
    end

    assign o_s_axis_tready = (r_state == ppue_pkg::ST_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out};

    // Configuration registers
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vary <= '0;
        end else if (cfg_wr) begin
            unique case (i_paddr[3:2])
                ppue_pkg::REG_VARY_X: r_vary[0] <= i_pwdata[ppue_pkg::VARY_W-1:0];
                ppue_pkg::REG_VARY_Y: r_vary[1] <= i_pwdata[ppue_pkg::VARY_W-1:0];
                ppue_pkg::REG_VARY_Z: r_vary[2] <= i_pwdata[ppue_pkg::VARY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[3:2])
            ppue_pkg::REG_VARY_X: o_prdata = {1'b0, r_vary[0]};
            ppue_pkg::REG_VARY_Y: o_prdata = {1'b0, r_vary[1]};
            ppue_pkg::REG_VARY_Z: o_prdata = {1'b0, r_vary[2]};
            default:              o_prdata = '0;
        endcase
    end

    // Tick sequencing
    assign tick_issue = (r_idx < ppue_pkg::POOL_CNT);
    assign tick_done  = !tick_issue && !r_v1 && !r_v2;

    // Emit: new slot contents, with final velocities from the registered jitter products
    always_comb begin
        logic signed [48:0] jit;
        emit_part.pos  = r_item.pos;
        emit_part.life = {1'b0, r_item.amount};
        for (int k = 0; k < 3; k++) begin
            jit = $signed(r_jit[k]) >>> 16;
            emit_part.vel[k] = ppue_pkg::sat32(64'($signed(r_item.vel[k])) + 64'(jit));
        end
    end

    // Tick write-back stage: age or retire one slot
    always_comb begin
        logic signed [63:0] step;
        tick_kill = r_v2 && r_live2 && ($signed(r_part2.life) <= 32'sd0);
        tick_wr   = r_v2 && r_live2 && ($signed(r_part2.life) > 32'sd0);
        tick_part.vel  = r_part2.vel;
        tick_part.life = ppue_pkg::sat32(64'($signed(r_part2.life))
                                         - 64'($signed({1'b0, r_item.amount})));
        for (int k = 0; k < 3; k++) begin
            step = $signed(r_prod2[k]) >>> 16;
            tick_part.pos[k] = ppue_pkg::sat32(64'($signed(r_part2.pos[k])) + step);
        end
    end

    assign read_in_range = (32'(r_item.slot) < 32'(ppue_pkg::POOL_SIZE));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppue_pkg::ST_CLEAR: begin
                if (r_idx == ppue_pkg::CLEAR_LAST) n_state = ppue_pkg::ST_IDLE;
            end
            ppue_pkg::ST_IDLE: begin
                if (s_acc) begin
                    case (in_item.func)
                        ppue_pkg::FUNC_EMIT: n_state = ppue_pkg::ST_EMIT_MUL;
                        ppue_pkg::FUNC_TICK: n_state = ppue_pkg::ST_TICK;
                        ppue_pkg::FUNC_READ: n_state = ppue_pkg::ST_READ_RD;
                        default:             n_state = ppue_pkg::ST_RESP;
                    endcase
                end
            end
            ppue_pkg::ST_EMIT_MUL: n_state = ppue_pkg::ST_EMIT_WR;
            ppue_pkg::ST_EMIT_WR:  n_state = ppue_pkg::ST_RESP;
            ppue_pkg::ST_TICK: begin
                if (tick_done) n_state = ppue_pkg::ST_RESP;
            end
            ppue_pkg::ST_READ_RD:  n_state = ppue_pkg::ST_READ_DT;
            ppue_pkg::ST_READ_DT:  n_state = ppue_pkg::ST_RESP;
            ppue_pkg::ST_RESP: begin
                if (out_free) n_state = ppue_pkg::ST_IDLE;
            end
            default: n_state = ppue_pkg::ST_IDLE;
        endcase
    end

    // Memory controls and count update
    always_comb begin
        flag_we    = 1'b0;
        flag_wdata = 1'b0;
        flag_waddr = '0;
        flag_raddr = '0;
        part_we    = 1'b0;
        part_waddr = '0;
        part_wdata = tick_part;
        part_raddr = '0;
        n_count    = r_count;
        unique case (r_state)
            ppue_pkg::ST_CLEAR: begin
                flag_we    = 1'b1;
                flag_waddr = r_idx[AW-1:0];
            end
            ppue_pkg::ST_EMIT_MUL: begin
                flag_raddr = r_wptr;
            end
            ppue_pkg::ST_EMIT_WR: begin
                part_we    = 1'b1;
                part_waddr = r_wptr;
                part_wdata = emit_part;
                flag_we    = 1'b1;
                flag_waddr = r_wptr;
                flag_wdata = 1'b1;
                if (!flag_rd) n_count = r_count + CW'(1);
            end
            ppue_pkg::ST_TICK: begin
                flag_raddr = r_idx[AW-1:0];
                part_raddr = r_idx[AW-1:0];
                part_we    = tick_wr;
                part_waddr = r_a2;
                flag_we    = tick_kill;
                flag_waddr = r_a2;
                if (tick_kill) n_count = r_count - CW'(1);
            end
            ppue_pkg::ST_READ_RD: begin
                flag_raddr = AW'(r_item.slot);
                part_raddr = AW'(r_item.slot);
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppue_pkg::ST_CLEAR;
            r_idx       <= '0;
            r_wptr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_v1    <= (r_state == ppue_pkg::ST_TICK) && tick_issue;
            r_v2    <= r_v1;
            if (r_state == ppue_pkg::ST_CLEAR) begin
                r_idx <= r_idx + CW'(1);
            end else if (s_acc) begin
                r_idx <= '0;
            end else if (r_state == ppue_pkg::ST_TICK && tick_issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (r_state == ppue_pkg::ST_EMIT_WR) begin
                r_wptr <= (r_wptr == '0) ? ppue_pkg::TOP_SLOT : r_wptr - AW'(1);
            end
            if (r_state == ppue_pkg::ST_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_item <= in_item;
            r_res  <= '0;
        end
        // jitter: vary times (rand - one half)
        if (r_state == ppue_pkg::ST_EMIT_MUL) begin
            for (int k = 0; k < 3; k++) begin
                r_jit[k] <= $signed({1'b0, r_vary[k]})
                          * ($signed({1'b0, r_item.rnd[k]}) - ppue_pkg::RAND_HALF);
            end
        end
        if (r_state == ppue_pkg::ST_EMIT_WR) begin
            r_res.number <= ppue_pkg::NUM_W'(r_wptr);
        end
        // tick: memory data in, motion products out
        r_a1    <= r_idx[AW-1:0];
        r_a2    <= r_a1;
        r_part2 <= part_rd;
        r_live2 <= flag_rd;
        for (int k = 0; k < 3; k++) begin
            r_prod2[k] <= $signed(part_rd.vel[k]) * $signed({1'b0, r_item.amount});
        end
        if (r_state == ppue_pkg::ST_TICK && tick_done) begin
            r_res.number <= ppue_pkg::NUM_W'(r_count);
        end
        if (r_state == ppue_pkg::ST_READ_DT) begin
            r_res.number <= ppue_pkg::NUM_W'(r_count);
            if (read_in_range) begin
                r_res.pos       <= part_rd.pos;
                r_res.vel       <= part_rd.vel;
                r_res.life      <= part_rd.life;
                r_res.is_active <= flag_rd;
            end
        end
        if (r_state == ppue_pkg::ST_RESP && out_free) begin
            r_out <= r_res;
        end
    end

    // Active flags, one bit per slot
    ppue_ram #(
        .WIDTH (1),
        .DEPTH (ppue_pkg::POOL_SIZE)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_raddr (flag_raddr),
        .o_rdata (flag_rd)
    );

    // Position, velocity and life per slot
    ppue_ram #(
        .WIDTH (ppue_pkg::PART_W),
        .DEPTH (ppue_pkg::POOL_SIZE)
    ) u_part_ram (
        .i_clk   (i_clk),
        .i_we    (part_we),
        .i_waddr (part_waddr),
        .i_wdata (part_wdata),
        .i_raddr (part_raddr),
        .o_rdata (part_rd)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ppue_pkg::POOL_CNT)
        else $error("active count beyond pool size");

    a_tick_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppue_pkg::ST_TICK && flag_we && tick_issue) |-> (flag_waddr != flag_raddr))
        else $error("tick write-back hits the slot being read");

    a_tick_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppue_pkg::ST_TICK && n_state != ppue_pkg::ST_TICK) |-> (!r_v1 && !r_v2))
        else $error("tick left with slots still in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state != ppue_pkg::ST_IDLE))
        else $error("engine still idle after taking a beat");
`endif

endmodule

`default_nettype wire
